>>> rtl/core/tbop_pkg.sv
// Package for the timer bank: transfer payload types, command codes,
// decoded operations and back-end states. It depends on nothing else.
`timescale 1ns / 1ps

package tbop_pkg;

   localparam logic [2:0]  CMD_CREATE  = 3'd0;
   localparam logic [2:0]  CMD_DISPOSE = 3'd1;
   localparam logic [2:0]  CMD_SET     = 3'd2;
   localparam logic [2:0]  CMD_START   = 3'd3;
   localparam logic [2:0]  CMD_STOP    = 3'd4;
   localparam logic [2:0]  CMD_TICK    = 3'd5;

   localparam logic        KIND_REPLY  = 1'b0;
   localparam logic        KIND_EXPIRY = 1'b1;

   localparam logic [31:0] SCALE       = 32'd1000;
   localparam int          QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_CREATE,
      OP_DISPOSE,
      OP_SET,
      OP_START,
      OP_STOP,
      OP_TICK,
      OP_BAD
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CREATE,
      ST_START,
      ST_TICK
   } st_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  slot_id;
      logic [22:0] delay;
      logic [22:0] period;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] result_slot;
      logic       ok;
      logic       last;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  slot_id;
      logic        id_ok;
      logic [31:0] delay;
      logic [31:0] period;
      logic [31:0] now_ms;
   } cmd_type;

endpackage

>>> rtl/core/tbop_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing else.
`timescale 1ns / 1ps

module tbop_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tbop_front.sv
// Front end of the timer bank: takes command transfers, decodes them,
// scales delay and period, and hands them to the queue. Uses tbop_pkg.
`timescale 1ns / 1ps

module tbop_front #(
   parameter int NUM_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tbop_pkg::req_type req_data,
   output logic              q_push,
   output tbop_pkg::cmd_type q_data,
   input  logic              q_full
);

   logic              f_vld_ff, f_vld_in;
   tbop_pkg::cmd_type f_data_ff, f_data_in;
   logic              accept;

   assign busy   = f_vld_ff && q_full;
   assign accept = start && !busy;
   assign q_push = f_vld_ff && !q_full;
   assign q_data = f_data_ff;

   always_comb begin
      f_data_in         = f_data_ff;
      f_vld_in          = f_vld_ff;
      if (q_push) begin
         f_vld_in = 1'b0;
      end
      if (accept) begin
         f_vld_in          = 1'b1;
         f_data_in.slot_id = req_data.slot_id;
         f_data_in.id_ok   = (32'(req_data.slot_id) < 32'(NUM_SLOTS));
         f_data_in.delay   = 32'(req_data.delay) * tbop_pkg::SCALE;
         f_data_in.period  = 32'(req_data.period) * tbop_pkg::SCALE;
         f_data_in.now_ms  = req_data.now_ms;
         case (req_data.cmd)
            tbop_pkg::CMD_CREATE:  f_data_in.op = tbop_pkg::OP_CREATE;
            tbop_pkg::CMD_DISPOSE: f_data_in.op = tbop_pkg::OP_DISPOSE;
            tbop_pkg::CMD_SET:     f_data_in.op = tbop_pkg::OP_SET;
            tbop_pkg::CMD_START:   f_data_in.op = tbop_pkg::OP_START;
            tbop_pkg::CMD_STOP:    f_data_in.op = tbop_pkg::OP_STOP;
            tbop_pkg::CMD_TICK:    f_data_in.op = tbop_pkg::OP_TICK;
            default:               f_data_in.op = tbop_pkg::OP_BAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= f_vld_in;
      end
      f_data_ff <= f_data_in;
   end

endmodule

>>> rtl/core/tbop_queue.sv
// Short flip-flop FIFO of decoded commands between the front and back ends.
// Uses tbop_pkg for the entry type and depth.
`timescale 1ns / 1ps

module tbop_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tbop_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output tbop_pkg::cmd_type head
);

   localparam int PTR_W = (tbop_pkg::QUEUE_DEPTH > 1) ? $clog2(tbop_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tbop_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tbop_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(tbop_pkg::QUEUE_DEPTH);

   tbop_pkg::cmd_type entry_ff [tbop_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/tbop_back.sv
// Back end of the timer bank: slot state, the slot RAMs and the sequencer
// that executes queued commands. Uses tbop_pkg and tbop_ram.
`timescale 1ns / 1ps

module tbop_back #(
   parameter int NUM_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  tbop_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   output tbop_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_SLOTS);

   tbop_pkg::st_type  state_ff, state_in;
   tbop_pkg::cmd_type cur_ff, cur_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0]  ev_idx_ff, ev_idx_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [NUM_SLOTS-1:0] used_ff, used_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tbop_pkg::rsp_type rsp_ff, rsp_in;

   logic [IDX_W-1:0]  head_idx, cur_idx, scan_idx;
   logic              head_hit, ev_hit;
   logic [IDX_W-1:0]  wr_idx, rd_idx;
   logic              dly_we, per_we, exp_we;
   logic [31:0]       dly_wdata, per_wdata, exp_wdata;
   logic [31:0]       dly_rd, per_rd, exp_rd;

   assign head_idx = IDX_W'(q_head.slot_id);
   assign cur_idx  = IDX_W'(cur_ff.slot_id);
   assign scan_idx = scan_ff[IDX_W-1:0];
   assign head_hit = q_head.id_ok && used_ff[head_idx];
   assign ev_hit   = used_ff[ev_idx_ff] && active_ff[ev_idx_ff] && (exp_rd <= cur_ff.now_ms);

   tbop_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_delay_ram (
      .clock   (clock),
      .wr_en   (dly_we),
      .wr_addr (wr_idx),
      .wr_data (dly_wdata),
      .rd_addr (rd_idx),
      .rd_data (dly_rd)
   );

   tbop_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (wr_idx),
      .wr_data (per_wdata),
      .rd_addr (rd_idx),
      .rd_data (per_rd)
   );

   tbop_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_expiry_ram (
      .clock   (clock),
      .wr_en   (exp_we),
      .wr_addr (wr_idx),
      .wr_data (exp_wdata),
      .rd_addr (rd_idx),
      .rd_data (exp_rd)
   );

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      scan_in      = scan_ff;
      ev_vld_in    = 1'b0;
      ev_idx_in    = ev_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_idx_in  = pend_idx_ff;
      used_in      = used_ff;
      active_in    = active_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      rd_idx       = head_idx;
      wr_idx       = head_idx;
      dly_we       = 1'b0;
      per_we       = 1'b0;
      exp_we       = 1'b0;
      dly_wdata    = '0;
      per_wdata    = '0;
      exp_wdata    = '0;

      case (state_ff)
         tbop_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop              = 1'b1;
               cur_in             = q_head;
               rsp_in.kind        = tbop_pkg::KIND_REPLY;
               rsp_in.result_slot = q_head.slot_id;
               rsp_in.ok          = head_hit;
               rsp_in.last        = 1'b1;
               case (q_head.op)
                  tbop_pkg::OP_CREATE: begin
                     scan_in  = '0;
                     state_in = tbop_pkg::ST_CREATE;
                  end
                  tbop_pkg::OP_DISPOSE: begin
                     if (head_hit) begin
                        used_in[head_idx]   = 1'b0;
                        active_in[head_idx] = 1'b0;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  tbop_pkg::OP_SET: begin
                     dly_we       = head_hit;
                     per_we       = head_hit;
                     dly_wdata    = q_head.delay;
                     per_wdata    = q_head.period;
                     rsp_valid_in = 1'b1;
                  end
                  tbop_pkg::OP_START: begin
                     if (head_hit) begin
                        state_in = tbop_pkg::ST_START;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  tbop_pkg::OP_STOP: begin
                     if (head_hit) begin
                        active_in[head_idx] = 1'b0;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  tbop_pkg::OP_TICK: begin
                     scan_in     = '0;
                     pend_vld_in = 1'b0;
                     state_in    = tbop_pkg::ST_TICK;
                  end
                  default: begin
                     rsp_in.ok    = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         tbop_pkg::ST_CREATE: begin
            rsp_in.kind = tbop_pkg::KIND_REPLY;
            rsp_in.last = 1'b1;
            if (scan_ff == SCAN_END) begin
               rsp_in.result_slot = '0;
               rsp_in.ok          = 1'b0;
               rsp_valid_in       = 1'b1;
               state_in           = tbop_pkg::ST_IDLE;
            end else if (!used_ff[scan_idx]) begin
               used_in[scan_idx]   = 1'b1;
               active_in[scan_idx] = 1'b0;
               wr_idx              = scan_idx;
               dly_we              = 1'b1;
               per_we              = 1'b1;
               exp_we              = 1'b1;
               rsp_in.result_slot  = 4'(scan_idx);
               rsp_in.ok           = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = tbop_pkg::ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         tbop_pkg::ST_START: begin
            wr_idx             = cur_idx;
            exp_we             = 1'b1;
            exp_wdata          = cur_ff.now_ms + ((dly_rd != '0) ? dly_rd : per_rd);
            active_in[cur_idx] = 1'b1;
            rsp_in.kind        = tbop_pkg::KIND_REPLY;
            rsp_in.result_slot = cur_ff.slot_id;
            rsp_in.ok          = 1'b1;
            rsp_in.last        = 1'b1;
            rsp_valid_in       = 1'b1;
            state_in           = tbop_pkg::ST_IDLE;
         end

         tbop_pkg::ST_TICK: begin
            rd_idx = scan_idx;
            if (scan_ff != SCAN_END) begin
               ev_vld_in = 1'b1;
               ev_idx_in = scan_idx;
               scan_in   = scan_ff + 1'b1;
            end
            rsp_in.kind = tbop_pkg::KIND_EXPIRY;
            rsp_in.ok   = 1'b1;
            if (ev_vld_ff) begin
               if (ev_hit) begin
                  wr_idx = ev_idx_ff;
                  if (per_rd != '0) begin
                     exp_we    = 1'b1;
                     exp_wdata = cur_ff.now_ms + per_rd;
                  end else begin
                     active_in[ev_idx_ff] = 1'b0;
                  end
                  rsp_in.result_slot = 4'(pend_idx_ff);
                  rsp_in.last        = 1'b0;
                  rsp_valid_in       = pend_vld_ff;
                  pend_vld_in        = 1'b1;
                  pend_idx_in        = ev_idx_ff;
               end
            end else if (scan_ff == SCAN_END) begin
               rsp_in.result_slot = 4'(pend_idx_ff);
               rsp_in.last        = 1'b1;
               rsp_valid_in       = pend_vld_ff;
               pend_vld_in        = 1'b0;
               state_in           = tbop_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tbop_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbop_pkg::ST_IDLE;
         ev_vld_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         used_ff      <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ev_vld_ff    <= ev_vld_in;
         pend_vld_ff  <= pend_vld_in;
         used_ff      <= used_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      scan_ff     <= scan_in;
      ev_idx_ff   <= ev_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_active_needs_used: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~used_ff) == '0)
      else $error("A slot is active without being allocated.");

   a_expiry_from_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && rsp_in.kind == tbop_pkg::KIND_EXPIRY) |-> state_ff == tbop_pkg::ST_TICK)
      else $error("An expiry notification was issued outside a tick scan.");

   a_pending_in_tick: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> state_ff == tbop_pkg::ST_TICK)
      else $error("A pending expiry survived the end of a tick scan.");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == tbop_pkg::ST_IDLE && !q_empty))
      else $error("The queue was popped while a command was still executing.");
`endif

endmodule

>>> rtl/core/timer_bank_oneshot_periodic.sv
// Top level of the command-driven timer bank with one-shot and periodic slots.
// Instantiates tbop_front, tbop_queue and tbop_back; uses tbop_pkg.
//
// A command is taken when start is high and busy is low; the front end and a
// two-entry queue take a new command every cycle until the queue is full and
// the front-end register holds a command. Each result is shown for one cycle
// with rsp_valid high and cannot be held off. The back end executes one
// command at a time: dispose, set, stop and unknown codes are executed in the
// idle state, start reads the slot RAMs and then does the arming write, create
// walks the slots looking for a free one, and tick reads one slot per cycle
// from the slot RAMs and evaluates it in the next. A command passes through
// the front-end register and the queue before execution begins, and each
// result is shown in the cycle after the back end produces it.
`timescale 1ns / 1ps

module timer_bank_oneshot_periodic #(
   parameter int NUM_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tbop_pkg::req_type req_data,
   output logic              rsp_valid,
   output tbop_pkg::rsp_type rsp_data
);

   logic              q_push, q_full, q_pop, q_empty;
   tbop_pkg::cmd_type q_data, q_head;

   tbop_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (q_data),
      .q_full   (q_full)
   );

   tbop_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   tbop_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
